// ===== rtl/core/crs_pkg.sv =====
package crs_pkg;

    // Multiplier digit: bits of the second operand consumed per cycle
    localparam int DIGIT_BITS = 8;

    // Sequencer counter, wide enough for the longest step count
    localparam int CNT_BITS = 6;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_MIN      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_MAX      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_COEF = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_LOAD1,
        S_MUL1,
        S_DIVLOAD,
        S_DIV,
        S_XCALC,
        S_LOAD2,
        S_MUL2,
        S_YCALC,
        S_FIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic clamp_en;
        logic mul1_load;
        logic mul2_load;
        logic mul_step;
        logic div_load;
        logic div_step;
        logic x_calc;
        logic y_calc;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic range_bad;
    } t_stat;

endpackage

// ===== rtl/core/crs_in_if.sv =====
interface crs_in_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_in;
    logic signed [DATA_WIDTH-1:0] out_low;
    logic signed [DATA_WIDTH-1:0] out_high;

    modport source (output valid, output sample_in, output out_low, output out_high,
                    input ready);
    modport sink   (input valid, input sample_in, input out_low, input out_high,
                    output ready);
endinterface

// ===== rtl/core/crs_out_if.sv =====
interface crs_out_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value_out;
    logic                         range_error;

    modport source (output valid, output value_out, output range_error, input ready);
    modport sink   (input valid, input value_out, input range_error, output ready);
endinterface

// ===== rtl/core/crs_ctrl.sv =====
module crs_ctrl import crs_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_BITS  = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);
    localparam int ND1 = (DATA_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int ND2 = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;

    // State, step counter and output word flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Clamp a word, then multiply, divide, smooth unless range is bad
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp_en = 1'b1;
                n_state        = i_stat.range_bad ? S_FIN : S_LOAD1;
            end
            S_LOAD1: begin
                o_cmd.mul1_load = 1'b1;
                n_cnt           = CNT_BITS'(ND1 - 1);
                n_state         = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DIVLOAD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIVLOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = CNT_BITS'(DATA_WIDTH - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_XCALC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_XCALC: begin
                o_cmd.x_calc = 1'b1;
                n_state      = S_LOAD2;
            end
            S_LOAD2: begin
                o_cmd.mul2_load = 1'b1;
                n_cnt           = CNT_BITS'(ND2 - 1);
                n_state         = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_YCALC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_YCALC: begin
                o_cmd.y_calc = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command active");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_load)
        else $error("output word overwritten before it was taken");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result load did not return to idle with a valid word");

    a_mul1_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> (r_cnt < CNT_BITS'(ND1)))
        else $error("multiply digit count out of range");

endmodule

// ===== rtl/core/crs_datapath.sv =====
module crs_datapath import crs_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cmd                                 i_cmd,
    output t_stat                                o_stat,
    input  logic                                 i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]              i_cfg_index,
    input  logic [((DATA_WIDTH > COEF_BITS) ? DATA_WIDTH : COEF_BITS)-1:0] i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0]         i_sample_in,
    input  logic signed [DATA_WIDTH-1:0]         i_out_low,
    input  logic signed [DATA_WIDTH-1:0]         i_out_high,
    output logic signed [DATA_WIDTH-1:0]         o_value_out,
    output logic                                 o_range_error
);
    localparam int W   = DATA_WIDTH;
    localparam int C   = COEF_BITS;
    localparam int DB  = DIGIT_BITS;
    localparam int ND1 = (W + DB - 1) / DB;
    localparam int ND2 = (C + DB - 1) / DB;
    localparam int MW  = (W > C) ? W : C;
    localparam int BW  = ((MW + DB - 1) / DB) * DB;
    localparam int AW  = W + BW;
    localparam logic [W-1:0]   IN_MAX_RST = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [W+C-1:0] HALF       = {{(W+C-1){1'b0}}, 1'b1} << (C - 1);

    // configuration and filter state
    logic signed [W-1:0] r_in_min, r_in_max, r_y;
    logic [C-1:0]        r_coef;
    // item operands
    logic signed [W-1:0] r_sample, r_lo, r_hi, r_clamp, r_x;
    logic [W-1:0]        r_dk_mag, r_span;
    logic                r_dk_neg, r_d_neg, r_err;
    // multiplier and divider
    logic [W-1:0]        r_ma;
    logic [BW-1:0]       r_mb;
    logic [AW-1:0]       r_acc;
    logic [W-1:0]        r_rem, r_dq;
    // output word
    logic signed [W-1:0] r_value_out;
    logic                r_range_error;

    logic                w_hi_below;
    logic                w_x_above;
    logic [DB-1:0]       w_digit;
    logic [W+DB-1:0]     w_pp;
    logic [W:0]          w_rem_sh;
    logic                w_ge;
    logic [W+C-1:0]      w_rnd;
    logic [W-1:0]        w_r;

    assign o_stat.range_bad = !(r_in_max > r_in_min);
    assign w_hi_below       = (r_hi < r_lo);
    assign w_x_above        = (r_x > r_y);
    assign w_digit          = r_mb[BW-1 -: DB];
    assign w_pp             = r_ma * w_digit;
    assign w_rem_sh         = {r_rem, r_dq[W-1]};
    assign w_ge             = (w_rem_sh >= {1'b0, r_span});
    assign w_rnd            = r_acc[W+C-1:0] + HALF;
    assign w_r              = w_rnd[W+C-1:C];

    // Write configuration and update the smoothed value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_min <= '0;
            r_in_max <= IN_MAX_RST;
            r_coef   <= '0;
            r_y      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IN_MIN:      r_in_min <= i_cfg_data[W-1:0];
                    REG_IN_MAX:      r_in_max <= i_cfg_data[W-1:0];
                    REG_SMOOTH_COEF: r_coef   <= i_cfg_data[C-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.y_calc) begin
                r_y <= r_d_neg ? (r_x - $signed(w_r)) : (r_x + $signed(w_r));
            end
        end
    end

    // Latch the word, clamp it, take the output span magnitude and form the scaled value
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_sample <= i_sample_in;
            r_lo     <= i_out_low;
            r_hi     <= i_out_high;
        end
        if (i_cmd.clamp_en) begin
            r_err    <= o_stat.range_bad;
            r_dk_neg <= w_hi_below;
            r_dk_mag <= w_hi_below ? (r_lo - r_hi) : (r_hi - r_lo);
            if (r_sample > r_in_max) begin
                r_clamp <= r_in_max;
            end else if (r_sample < r_in_min) begin
                r_clamp <= r_in_min;
            end else begin
                r_clamp <= r_sample;
            end
        end
        if (i_cmd.x_calc) begin
            r_x <= r_dk_neg ? (r_lo - $signed(r_dq)) : (r_lo + $signed(r_dq));
        end
    end

    // Digit-serial multiplier, most significant digit first
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1_load) begin
            r_ma   <= r_clamp - r_in_min;
            r_mb   <= BW'(r_dk_mag) << (BW - ND1 * DB);
            r_acc  <= '0;
            r_span <= r_in_max - r_in_min;
        end else if (i_cmd.mul2_load) begin
            r_ma    <= w_x_above ? (r_x - r_y) : (r_y - r_x);
            r_d_neg <= w_x_above;
            r_mb    <= BW'(r_coef) << (BW - ND2 * DB);
            r_acc   <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc <= (r_acc << DB) + AW'(w_pp);
            r_mb  <= r_mb << DB;
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= r_acc[2*W-1:W];
            r_dq  <= r_acc[W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? W'(w_rem_sh - {1'b0, r_span}) : w_rem_sh[W-1:0];
            r_dq  <= {r_dq[W-2:0], w_ge};
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value_out   <= r_y;
            r_range_error <= r_err;
        end
    end

    assign o_value_out   = r_value_out;
    assign o_range_error = r_range_error;

endmodule

// ===== rtl/core/clamped_range_scaler_with_smoothing_top.sv =====
// Sequence: each input word passes through clamp, an 8-bit digit-serial multiply by the
//   output span, a restoring divide by the input span, a smoothing multiply and the output
//   load; a bad input range goes from clamp straight to the output load. A new word is taken
//   only after the last one is loaded into the output register, and that load waits while
//   the previous output word is not taken. The divider gives one quotient bit per cycle.
// Reset: synchronous, active low; restores register defaults and clears the smoothed value.
module clamped_range_scaler_with_smoothing_top import crs_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    crs_in_if.sink                  i_sample,
    crs_out_if.source               o_result,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [((DATA_WIDTH > COEF_BITS) ? DATA_WIDTH : COEF_BITS)-1:0] i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    crs_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_BITS  (COEF_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    crs_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample_in   (i_sample.sample_in),
        .i_out_low     (i_sample.out_low),
        .i_out_high    (i_sample.out_high),
        .o_value_out   (o_result.value_out),
        .o_range_error (o_result.range_error)
    );

    assign i_sample.ready = w_in_ready;
    assign o_result.valid = w_out_valid;

endmodule
